[hw/rtl/t3c_pkg.sv]
// t3c_pkg: shared types, widths and register codes for the thresholded 3x3 convolution
// depends on nothing
`default_nettype none
package t3c_pkg;
  localparam int PIX_W   = 16;
  localparam int COEF_W  = 16;
  localparam int ACC_W   = 40;
  localparam int CSUM_W  = 20;
  localparam int CFG_W   = 64;
  localparam int CIDX_W  = 3;
  localparam int QUEUE_DEPTH = 4;
  localparam int OUT_FIFO_DEPTH = 64;
  localparam int DIV_STEPS = ACC_W;

  localparam logic [CIDX_W-1:0] REG_MODE   = 3'd0;
  localparam logic [CIDX_W-1:0] REG_DEPTH  = 3'd1;
  localparam logic [CIDX_W-1:0] REG_PACK_L = 3'd2;
  localparam logic [CIDX_W-1:0] REG_PACK_H = 3'd3;
  localparam logic [CIDX_W-1:0] REG_CENTER = 3'd4;
  localparam logic [CIDX_W-1:0] REG_DIV    = 3'd5;

  // classified item handed from front to back
  typedef struct packed {
    logic                     bypass;
    logic [PIX_W-1:0]         centre;
    logic signed [ACC_W-1:0]  num;
    logic signed [CSUM_W-1:0] den;
    logic [15:0]              top;
  } t3c_job_t;
endpackage
`default_nettype wire

[hw/rtl/t3c_front.sv]
// t3c_front: threshold test, products and sums for one window, two pipeline stages
// depends on t3c_pkg
`default_nettype none
module t3c_front import t3c_pkg::*; (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    en,
  input  wire logic                    in_vld,
  input  wire logic [8:0][PIX_W-1:0]   pix,
  input  wire logic [PIX_W-1:0]        limit,
  input  wire logic                    mode,
  input  wire logic [4:0]              depth,
  input  wire logic [7:0][COEF_W-1:0]  coefs,
  input  wire logic signed [COEF_W-1:0] coef_c,
  input  wire logic [14:0]             divisor,
  output logic                         out_vld,
  output t3c_job_t                     job
);
  // stage 1: products
  logic                     s1_vld_r;
  logic signed [33:0]       prod_r [9];
  logic signed [COEF_W:0]   used_r [9];
  logic [PIX_W-1:0]         c_r;
  logic                     mode_r;
  logic [15:0]              top_r;
  logic [14:0]              div_r;
  logic [3:0]               d_sel;

  always_comb begin
    d_sel = (depth < 5'd10) ? 4'd10 : (depth > 5'd16) ? 4'd0 : depth[3:0];
  end

  always_ff @(posedge clk) begin
    logic [16:0] diff;
    logic        pass;
    logic [PIX_W-1:0] p;
    if (!rst_n) s1_vld_r <= 1'b0;
    else if (en) s1_vld_r <= in_vld;
    if (en) begin
      c_r    <= pix[4];
      mode_r <= mode;
      div_r  <= divisor;
      top_r  <= (d_sel == 4'd0) ? 16'hFFFF : 16'((17'd1 << d_sel) - 17'd1);
      prod_r[8] <= $signed({1'b0, pix[4]}) * coef_c;
      used_r[8] <= {coef_c[COEF_W-1], coef_c};
      for (int k = 0; k < 8; k++) begin
        p = pix[k < 4 ? k : k + 1];
        diff = (p >= pix[4]) ? {1'b0, p - pix[4]} : {1'b0, pix[4] - p};
        pass = diff < {1'b0, limit};
        // drop mode skips a failing neighbour, replace mode weights the centre
        prod_r[k] <= (!pass && mode) ? 34'sd0 :
                     $signed({1'b0, (pass ? p : pix[4])}) * $signed(coefs[k]);
        used_r[k] <= pass ? {coefs[k][COEF_W-1], coefs[k]} : '0;
      end
    end
  end

  // stage 2: sums and divisor choice
  always_ff @(posedge clk) begin
    logic signed [ACC_W-1:0]  s;
    logic signed [CSUM_W-1:0] cs;
    if (!rst_n) out_vld <= 1'b0;
    else if (en) out_vld <= s1_vld_r;
    if (en) begin
      s = '0;
      cs = '0;
      for (int k = 0; k < 9; k++) begin
        s  = s + ACC_W'(prod_r[k]);
        cs = cs + CSUM_W'(used_r[k]);
      end
      job.centre <= c_r;
      job.num    <= s;
      job.den    <= mode_r ? cs : CSUM_W'({1'b0, div_r});
      job.bypass <= mode_r ? (cs == '0) : (div_r == '0);
      job.top    <= top_r;
    end
  end
endmodule
`default_nettype wire

[hw/rtl/t3c_queue.sv]
// t3c_queue: small register queue between the front and the back
// depends on t3c_pkg
`default_nettype none
module t3c_queue import t3c_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     wr,
  input  wire t3c_job_t wdata,
  input  wire logic     rd,
  output t3c_job_t      rdata,
  output logic          nonempty
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  t3c_job_t mem [DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [$clog2(DEPTH+1)-1:0] cnt_r;

  assign nonempty = cnt_r != '0;
  assign rdata = mem[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (wr) wp_r <= (wp_r == AW'(DEPTH-1)) ? '0 : wp_r + 1'b1;
      if (rd) rp_r <= (rp_r == AW'(DEPTH-1)) ? '0 : rp_r + 1'b1;
      cnt_r <= cnt_r + (wr ? 1'b1 : 1'b0) - (rd ? 1'b1 : 1'b0);
    end
    if (wr) mem[wp_r] <= wdata;
  end
endmodule
`default_nettype wire

[hw/rtl/t3c_back.sv]
// t3c_back: pipelined signed restoring divider, rounding and clip, one bit a stage
// depends on t3c_pkg
`default_nettype none
module t3c_back import t3c_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             en,
  input  wire logic             in_vld,
  input  wire t3c_job_t         job,
  output logic                  out_vld,
  output logic [PIX_W-1:0]      pix
);
  localparam int N = DIV_STEPS;
  typedef struct packed {
    logic                    vld;
    logic                    bypass;
    logic                    neg;
    logic [PIX_W-1:0]        centre;
    logic [15:0]             top;
    logic [N-1:0]            quo;
    logic [N:0]              rem;
    logic [CSUM_W-1:0]       dmag;
  } dstage_t;

  dstage_t st_r [N+1];

  // stage 0 rounds and takes magnitudes, each later stage settles one quotient bit,
  // the output register clips
  always_ff @(posedge clk) begin
    logic signed [ACC_W:0]    a;
    logic signed [CSUM_W-1:0] h;
    logic [N:0]               r;
    logic [N:0]               t;
    dstage_t                  s0;
    dstage_t                  nx;
    dstage_t                  f;
    if (!rst_n) begin
      for (int i = 0; i <= N; i++) st_r[i].vld <= 1'b0;
      out_vld <= 1'b0;
    end else if (en) begin
      h = job.den / 2;
      a = {job.num[ACC_W-1], job.num} + (ACC_W+1)'(h);
      s0.vld    = in_vld;
      s0.bypass = job.bypass;
      s0.centre = job.centre;
      s0.top    = job.top;
      s0.neg    = a[ACC_W] ^ job.den[CSUM_W-1];
      s0.quo    = N'(a[ACC_W] ? -a : a);
      s0.rem    = '0;
      s0.dmag   = job.den[CSUM_W-1] ? CSUM_W'(-job.den) : job.den;
      st_r[0] <= s0;
      for (int i = 0; i < N; i++) begin
        nx = st_r[i];
        r = {st_r[i].rem[N-1:0], st_r[i].quo[N-1]};
        t = r - (N+1)'(st_r[i].dmag);
        nx.rem = t[N] ? r : t;
        nx.quo = {st_r[i].quo[N-2:0], ~t[N]};
        st_r[i+1] <= nx;
      end
      f = st_r[N];
      out_vld <= f.vld;
      if (f.bypass) pix <= f.centre;
      else if (f.neg && f.quo != '0) pix <= '0;
      else if (f.quo > N'(f.top)) pix <= f.top;
      else pix <= f.quo[PIX_W-1:0];
    end
  end
endmodule
`default_nettype wire

[hw/rtl/thresholded_3x3_convolution.sv]
// thresholded_3x3_convolution: top level, registers, front, queue, back and output fifo
// depends on t3c_pkg, t3c_front, t3c_queue, t3c_back
//
//  channel | handshake      | payload
//  in      | in_push/in_full | pix_* and limit, 16 bits each
//  out     | out_pop/out_empty | pix_out, 16 bits
//  cfg     | cfg_we          | cfg_idx 3 bits, cfg_data 64 bits
//
// one window a cycle sustained while in_full stays low; a result shows on the out ports once
// its request has passed 2 front stages, 1 queue slot, 42 back stages (rounding, 40 divide
// steps, clip) and the fifo head register
// reset (rst_n low, synchronous) clears all queues and restores register defaults
// the pipeline itself never stalls; in_full rises once requests in flight plus results
// held reach the fifo depth, so a stalled result side blocks input after 64 requests
`default_nettype none
module thresholded_3x3_convolution import t3c_pkg::*; #(
  parameter int OUT_DEPTH = OUT_FIFO_DEPTH
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_push,
  output logic                   in_full,
  input  wire logic [PIX_W-1:0]  in_pix_tl, in_pix_t, in_pix_tr, in_pix_l, in_pix_c,
  input  wire logic [PIX_W-1:0]  in_pix_r, in_pix_bl, in_pix_b, in_pix_br, in_limit,
  output logic                   out_empty,
  input  wire logic              out_pop,
  output logic [PIX_W-1:0]       out_pix_out,
  input  wire logic              cfg_we,
  input  wire logic [CIDX_W-1:0] cfg_idx,
  input  wire logic [CFG_W-1:0]  cfg_data
);
  localparam int OAW = (OUT_DEPTH > 1) ? $clog2(OUT_DEPTH) : 1;
  localparam int OCW = $clog2(OUT_DEPTH+1);

  // configuration registers
  logic mode_r; logic [4:0] depth_r; logic [63:0] pl_r, ph_r;
  logic signed [15:0] cc_r; logic [14:0] div_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0; depth_r <= 5'd16; pl_r <= '0; ph_r <= '0;
      cc_r <= 16'sd1; div_r <= 15'd1;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_MODE:   mode_r  <= cfg_data[0];
        REG_DEPTH:  depth_r <= cfg_data[4:0];
        REG_PACK_L: pl_r    <= cfg_data;
        REG_PACK_H: ph_r    <= cfg_data;
        REG_CENTER: cc_r    <= cfg_data[15:0];
        REG_DIV:    div_r   <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  // credit: items in flight plus stored must fit in the output fifo
  logic [OCW:0] inflight_r;
  logic [OCW-1:0] ocnt_r;
  logic run, acc, back_vld, fr_vld;
  logic [PIX_W-1:0] back_pix;
  t3c_job_t fr_job, q_job;
  logic q_ne;
  logic pop_ok;

  assign run = 1'b1;
  assign pop_ok = out_pop && !out_empty;
  assign in_full = (inflight_r + {1'b0, ocnt_r}) >= (OCW+1)'(OUT_DEPTH);
  assign acc = in_push && !in_full;

  always_ff @(posedge clk) begin
    if (!rst_n) inflight_r <= '0;
    else inflight_r <= inflight_r + (acc ? 1'b1 : 1'b0) - (back_vld ? 1'b1 : 1'b0);
  end

  t3c_front u_front (
    .clk, .rst_n, .en(run), .in_vld(acc),
    .pix({in_pix_br, in_pix_b, in_pix_bl, in_pix_r, in_pix_c,
          in_pix_l, in_pix_tr, in_pix_t, in_pix_tl}),
    .limit(in_limit), .mode(mode_r), .depth(depth_r),
    .coefs({ph_r, pl_r}), .coef_c(cc_r), .divisor(div_r),
    .out_vld(fr_vld), .job(fr_job)
  );

  // front to back job queue; back always drains, so it never exceeds one entry
  t3c_queue u_queue (
    .clk, .rst_n, .wr(fr_vld), .wdata(fr_job), .rd(q_ne),
    .rdata(q_job), .nonempty(q_ne)
  );

  t3c_back u_back (
    .clk, .rst_n, .en(run), .in_vld(q_ne), .job(q_job),
    .out_vld(back_vld), .pix(back_pix)
  );

  // result fifo: memory with registered read behind a head register
  // the head is refilled from memory first, straight from the back when memory is empty
  logic [PIX_W-1:0] omem [OUT_DEPTH];
  logic [OAW-1:0] owp_r, orp_r;
  logic [OCW-1:0] mcnt_r;
  logic head_vld_r;
  logic [PIX_W-1:0] head_r;
  logic head_ld, ld_mem, ld_back, mem_wr;

  assign head_ld = !head_vld_r || pop_ok;
  assign ld_mem  = head_ld && (mcnt_r != '0);
  assign ld_back = head_ld && (mcnt_r == '0) && back_vld;
  assign mem_wr  = back_vld && !ld_back;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owp_r <= '0; orp_r <= '0; ocnt_r <= '0; mcnt_r <= '0; head_vld_r <= 1'b0;
    end else begin
      if (mem_wr) owp_r <= (owp_r == OAW'(OUT_DEPTH-1)) ? '0 : owp_r + 1'b1;
      if (ld_mem) orp_r <= (orp_r == OAW'(OUT_DEPTH-1)) ? '0 : orp_r + 1'b1;
      ocnt_r <= ocnt_r + (back_vld ? 1'b1 : 1'b0) - (pop_ok ? 1'b1 : 1'b0);
      mcnt_r <= mcnt_r + (mem_wr ? 1'b1 : 1'b0) - (ld_mem ? 1'b1 : 1'b0);
      if (head_ld) head_vld_r <= ld_mem || ld_back;
    end
    if (mem_wr) omem[owp_r] <= back_pix;
    if (ld_mem) head_r <= omem[orp_r];
    else if (ld_back) head_r <= back_pix;
  end
  assign out_empty = !head_vld_r;
  assign out_pix_out = head_r;
endmodule
`default_nettype wire

[hw/rtl/t3c_checker.sv]
// t3c_checker: port-level assertions for thresholded_3x3_convolution, and its bind
// depends on t3c_pkg
`default_nettype none
module t3c_checker import t3c_pkg::*; (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_push,
  input wire logic in_full,
  input wire logic out_empty,
  input wire logic out_pop,
  input wire logic [PIX_W-1:0] out_pix_out
);
  // after reset nothing is waiting
  a_rst_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("results after reset");
  a_rst_room: assert property (@(posedge clk) !rst_n |=> !in_full)
    else $error("full after reset");
  // handshake lines always resolved
  a_known: assert property (@(posedge clk) disable iff (!rst_n)
    !$isunknown({in_push, in_full, out_empty, out_pop}))
    else $error("handshake line unknown");
  // a waiting result carries a defined value
  a_data_known: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> !$isunknown(out_pix_out))
    else $error("result value unknown");
  // a waiting result holds until popped
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_pix_out)))
    else $error("result changed while stalled");
endmodule

bind thresholded_3x3_convolution t3c_checker u_chk (
  .clk, .rst_n, .in_push, .in_full, .out_empty, .out_pop, .out_pix_out
);
`default_nettype wire
